/* rtl/rc4_pkg.sv */
package rc4_pkg;

	// table geometry
	localparam int TABLE_SIZE = 256;
	localparam logic [7:0] TABLE_LAST = 8'(TABLE_SIZE - 1);
	localparam int KEY_BYTES_DEF = 128;

	// item kinds
	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_SCHED = 2'd1,
		KIND_CRYPT = 2'd2,
		KIND_NONE  = 2'd3
	} rc4_kind_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_KSA_RD,
		ST_KSA_ACC,
		ST_KSA_SWA,
		ST_KSA_SWB,
		ST_PRGA_RDI,
		ST_PRGA_RDJ,
		ST_PRGA_SWP,
		ST_PRGA_OUT
	} rc4_state_t;

	// request to a byte-wide memory: one write and one read port
	typedef struct packed {
		logic       we;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic       re;
		logic [7:0] raddr;
	} rc4_mem_req_t;

endpackage

/* rtl/rc4_perm_mem.sv */
module rc4_perm_mem
	import rc4_pkg::*;
(
	input  logic         clk,
	input  rc4_mem_req_t req,
	output logic [7:0]   rdata
);

	logic [7:0] mem [TABLE_SIZE];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rc4_key_mem.sv */
module rc4_key_mem
	import rc4_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  rc4_mem_req_t req,
	output logic [7:0]   rdata
);

	localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	logic [7:0]           mem [KEY_BYTES];
	logic [KEY_BYTES-1:0] vld_q;
	logic [7:0]           rdata_q;
	logic                 vld_s1;

	// key bytes
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[KW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr[KW-1:0]];
		end
	end

	// written flags, an unwritten byte reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr[KW-1:0]] <= 1'b1;
			end
			if (req.re) begin
				vld_s1 <= vld_q[req.raddr[KW-1:0]];
			end
		end
	end

	assign rdata = vld_s1 ? rdata_q : 8'd0;

endmodule

/* rtl/rc4_ctrl.sv */
module rc4_ctrl
	import rc4_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   kind,
	input  logic [7:0]   key_index,
	input  logic [7:0]   key_byte,
	input  logic [7:0]   data_byte,
	input  logic         last_in,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   data_out,
	output logic         last_out,
	output rc4_mem_req_t perm_req,
	input  logic [7:0]   perm_rdata,
	output rc4_mem_req_t key_req,
	input  logic [7:0]   key_rdata
);

	localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	rc4_state_t state_q, state_d;
	rc4_kind_t  kind_w;

	logic [7:0]    cnt_q;
	logic [7:0]    acc_q;
	logic [KW-1:0] kp_q;
	logic [7:0]    i_q, j_q;
	logic          init_q;
	logic          out_valid_q;
	logic [7:0]    si_q, sj_q, t_q, din_q, data_out_q;
	logic          last_q, last_out_q;

	logic       in_acc, out_free, key_in_range;
	logic [7:0] rd, acc_sum, j_sum, t_sum, ks;

	assign kind_w       = rc4_kind_t'(kind);
	assign in_ready     = (state_q == ST_IDLE);
	assign in_acc       = in_valid && in_ready;
	assign out_free     = !out_valid_q || out_ready;
	assign key_in_range = ({1'b0, key_index} < 9'(KEY_BYTES));

	// table reads as zero until the first schedule fills it
	assign rd = init_q ? perm_rdata : 8'd0;

	// datapath arithmetic
	assign acc_sum = acc_q + rd + key_rdata;
	assign j_sum   = j_q + rd;
	assign t_sum   = si_q + rd;

	// keystream read overlapped the write of S[i]; S[j] gets its swap later
	assign ks = (t_q == i_q) ? sj_q :
	            (t_q == j_q) ? si_q : rd;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (kind_w)
						KIND_SCHED: state_d = ST_INIT;
						KIND_CRYPT: state_d = ST_PRGA_RDI;
						KIND_KEY, KIND_NONE: state_d = ST_IDLE;
					endcase
				end
			end
			ST_INIT: begin
				if (cnt_q == TABLE_LAST) begin
					state_d = ST_KSA_RD;
				end
			end
			ST_KSA_RD:  state_d = ST_KSA_ACC;
			ST_KSA_ACC: state_d = ST_KSA_SWA;
			ST_KSA_SWA: state_d = ST_KSA_SWB;
			ST_KSA_SWB: begin
				state_d = (cnt_q == TABLE_LAST) ? ST_IDLE : ST_KSA_RD;
			end
			ST_PRGA_RDI: state_d = ST_PRGA_RDJ;
			ST_PRGA_RDJ: state_d = ST_PRGA_SWP;
			ST_PRGA_SWP: state_d = ST_PRGA_OUT;
			ST_PRGA_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// memory requests
	always_comb begin
		perm_req = '0;
		key_req  = '0;
		unique case (state_q)
			ST_IDLE: begin
				key_req.we    = in_acc && (kind_w == KIND_KEY) && key_in_range;
				key_req.waddr = key_index;
				key_req.wdata = key_byte;
			end
			ST_INIT: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = cnt_q;
				perm_req.wdata = cnt_q;
			end
			ST_KSA_RD: begin
				perm_req.re   = 1'b1;
				perm_req.raddr = cnt_q;
				key_req.re    = 1'b1;
				key_req.raddr = 8'(kp_q);
			end
			ST_KSA_ACC: begin
				perm_req.re    = 1'b1;
				perm_req.raddr = acc_sum;
			end
			ST_KSA_SWA: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = cnt_q;
				perm_req.wdata = rd;
			end
			ST_KSA_SWB: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = acc_q;
				perm_req.wdata = si_q;
			end
			ST_PRGA_RDI: begin
				perm_req.re    = 1'b1;
				perm_req.raddr = i_q;
			end
			ST_PRGA_RDJ: begin
				perm_req.re    = 1'b1;
				perm_req.raddr = j_sum;
			end
			ST_PRGA_SWP: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = i_q;
				perm_req.wdata = rd;
				perm_req.re    = 1'b1;
				perm_req.raddr = t_sum;
			end
			ST_PRGA_OUT: begin
				perm_req.we    = 1'b1;
				perm_req.waddr = j_q;
				perm_req.wdata = si_q;
			end
		endcase
	end

	// control state and cipher indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			acc_q       <= '0;
			kp_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// output word loads when free, drops once taken
			if (state_q == ST_PRGA_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind_w == KIND_SCHED) begin
						cnt_q  <= '0;
						acc_q  <= '0;
						kp_q   <= '0;
						init_q <= 1'b1;
					end
					if (in_acc && kind_w == KIND_CRYPT) begin
						i_q <= i_q + 8'd1;
					end
				end
				ST_INIT: cnt_q <= cnt_q + 8'd1;
				ST_KSA_ACC: acc_q <= acc_sum;
				ST_KSA_SWB: begin
					cnt_q <= cnt_q + 8'd1;
					kp_q  <= (kp_q == KW'(KEY_BYTES - 1)) ? '0 : kp_q + KW'(1);
					if (cnt_q == TABLE_LAST) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				ST_PRGA_RDJ: j_q <= j_sum;
				default: ;
			endcase
		end
	end

	// held table bytes and the output word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					din_q  <= data_byte;
					last_q <= last_in;
				end
			end
			ST_KSA_ACC:  si_q <= rd;
			ST_PRGA_RDJ: si_q <= rd;
			ST_PRGA_SWP: begin
				sj_q <= rd;
				t_q  <= t_sum;
			end
			ST_PRGA_OUT: begin
				if (out_free) begin
					data_out_q <= din_q ^ ks;
					last_out_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign last_out  = last_out_q;

endmodule

/* rtl/rc4_stream_cipher.sv */
// RC4 stream cipher with the permutation table and key in on-chip memories.
// Input channel (in_valid/in_ready) carries one word per item, selected by kind:
//   key byte  : writes key_byte at key_index (ignored at or above KEY_BYTES),
//               in_ready stays high
//   schedule  : identity fill of the table, then the key schedule; each step
//               reads, accumulates and swaps over two writes on the single table
//               read port; in_ready stays low until the schedule ends, indices
//               cleared
//   crypt byte: data_byte XOR keystream; out_valid rises once its steps are done
//               (two dependent table reads,
//               a swap over two writes, overlapped keystream read)
//   kind 3    : no effect
// Output channel (out_valid/out_ready) carries data_out and last_out, one word
// per crypt byte, in order. A stalled receiver holds the output word; a crypt
// byte accepted meanwhile runs and then waits in its last step for the output
// register to free up.
// Reset clears the indices and control; table and key read as zero until
// written (flag based, no clearing pass), so data passes through unchanged
// until the first schedule.
module rc4_stream_cipher
	import rc4_pkg::*;
#(
	parameter int KEY_BYTES = KEY_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] key_index,
	input  logic [7:0] key_byte,
	input  logic [7:0] data_byte,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out,
	output logic       last_out
);

	rc4_mem_req_t perm_req, key_req;
	logic [7:0]   perm_rdata, key_rdata;

	// sequencer and datapath
	rc4_ctrl #(
		.KEY_BYTES(KEY_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.key_index (key_index),
		.key_byte  (key_byte),
		.data_byte (data_byte),
		.last_in   (last_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.last_out  (last_out),
		.perm_req  (perm_req),
		.perm_rdata(perm_rdata),
		.key_req   (key_req),
		.key_rdata (key_rdata)
	);

	// permutation table
	rc4_perm_mem u_perm_mem (
		.clk  (clk),
		.req  (perm_req),
		.rdata(perm_rdata)
	);

	// key store
	rc4_key_mem #(
		.KEY_BYTES(KEY_BYTES)
	) u_key_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (key_req),
		.rdata (key_rdata)
	);

endmodule

/* rtl/rc4_checker.sv */
module rc4_checker
	import rc4_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] data_out,
	input logic       last_out
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(last_out))
		else $error("output word changed while stalled");

	// schedule and crypt items occupy the block
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_SCHED || kind == KIND_CRYPT) |=> !in_ready)
		else $error("block took a word while busy");

	// key writes and no-ops complete at once
	a_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_KEY || kind == KIND_NONE) |=> in_ready)
		else $error("key write or no-op stalled the input");

	// crypt byte with an empty output register keeps out_valid low until its result appears
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_CRYPT && !out_valid |-> ##4 !out_valid ##1 out_valid)
		else $error("crypt result latency off");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.kind     (kind),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.data_out (data_out),
	.last_out (last_out)
);
